>>> rtl/pihex_pkg.sv
// ============================================================================
// pihex_pkg
// Shared widths, types, codes and the face corner-order tables of the
// point-in-hexahedron test.
// ============================================================================
package pihex_pkg;

  // Coordinate width and every width derived from it.
  localparam int COORD_W = 32;
  // A difference of two coordinates.
  localparam int DIFF_W  = COORD_W + 1;
  // Operand width of the shared multipliers (a difference plus one bit,
  // so the upper half of a normal component also fits).
  localparam int MUL_W   = DIFF_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  // A normal component: difference of two cross-product terms.
  localparam int NORM_W  = 2 * DIFF_W + 1;
  // A sum of three products.
  localparam int SUM_W   = PROD_W + 1;
  // The full dot product rebuilt from its two halves.
  localparam int DOT_W   = SUM_W + DIFF_W + 1;

  localparam int NUM_CORNERS = 8;
  localparam int CIDX_W      = $clog2(NUM_CORNERS);
  localparam int NUM_FACES   = 6;
  localparam int FACE_W      = $clog2(NUM_FACES);
  localparam int NUM_LANES   = 3;

  // Input beat modes.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Operand selection of the multiplier lanes.
  localparam logic [1:0] MS_CROSS0 = 2'd0;
  localparam logic [1:0] MS_CROSS1 = 2'd1;
  localparam logic [1:0] MS_DOT_LO = 2'd2;
  localparam logic [1:0] MS_DOT_HI = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } corner_t;

  typedef struct packed {
    logic [CIDX_W-1:0] c0;
    logic [CIDX_W-1:0] c1;
    logic [CIDX_W-1:0] c2;
  } face_t;

  // Step enables from the sequencer to the face datapath.
  typedef struct packed {
    logic       cap_a;
    logic       cap_b;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       save_p1;
    logic       norm;
    logic       lo_sum;
    logic       hi_sum;
  } pihex_ctl_t;

  // Signed difference of two coordinates, exact.
  function automatic logic signed [DIFF_W-1:0] coord_diff(
    input logic [COORD_W-1:0] a,
    input logic [COORD_W-1:0] b
  );
    logic signed [DIFF_W-1:0] ea;
    logic signed [DIFF_W-1:0] eb;
    ea = signed'({a[COORD_W-1], a});
    eb = signed'({b[COORD_W-1], b});
    return ea - eb;
  endfunction

  // Corners c0, c1, c2 of a face. The fourth corner of each face in the
  // tables plays no part in the test and is left out.
  function automatic face_t face_corners(
    input logic              order,
    input logic [FACE_W-1:0] face
  );
    face_t f;
    unique case ({order, face})
      {1'b0, 3'd0}: f = '{c0: 3'd0, c1: 3'd2, c2: 3'd1};
      {1'b0, 3'd1}: f = '{c0: 3'd4, c1: 3'd5, c2: 3'd6};
      {1'b0, 3'd2}: f = '{c0: 3'd0, c1: 3'd4, c2: 3'd2};
      {1'b0, 3'd3}: f = '{c0: 3'd1, c1: 3'd3, c2: 3'd5};
      {1'b0, 3'd4}: f = '{c0: 3'd0, c1: 3'd1, c2: 3'd4};
      {1'b0, 3'd5}: f = '{c0: 3'd2, c1: 3'd6, c2: 3'd3};
      {1'b1, 3'd0}: f = '{c0: 3'd2, c1: 3'd0, c2: 3'd3};
      {1'b1, 3'd1}: f = '{c0: 3'd6, c1: 3'd7, c2: 3'd4};
      {1'b1, 3'd2}: f = '{c0: 3'd2, c1: 3'd6, c2: 3'd0};
      {1'b1, 3'd3}: f = '{c0: 3'd3, c1: 3'd1, c2: 3'd7};
      {1'b1, 3'd4}: f = '{c0: 3'd2, c1: 3'd3, c2: 3'd6};
      {1'b1, 3'd5}: f = '{c0: 3'd0, c1: 3'd4, c2: 3'd1};
      default:      f = '{c0: 3'd0, c1: 3'd0, c2: 3'd0};
    endcase
    return f;
  endfunction

endpackage

>>> rtl/point_in_hexahedron_test.sv
// ============================================================================
// point_in_hexahedron_test
// Tells whether a query point lies inside a hexahedral cell held as eight
// corners.
// ============================================================================
// A load beat (mode 0) writes one corner into the corner store and gives no
// result. A query beat (mode 1) walks the six faces of the cell and gives one
// result beat, inside_res, which is 1 when the point lies on the inner side of
// every face or on a face. Each face reads its corners from the two-port
// corner store, forms the cross product on three shared 34x34 multipliers,
// forms the normal, and then the dot product, done as a low and a high half on
// the same multipliers and summed. A query occupies the block from its beat
// until its result is handed to the output register; when an earlier result
// still waits there under a stall, the hand-over waits for as long as that
// result is not taken. The input is stalled during that time. Load and query
// beats are accepted while a finished result still waits in the output
// register. The face_order register picks one of two corner-order tables and
// must only be written while no query is in progress. Corners must be loaded
// before a query uses them; the store has no reset value.
// ============================================================================
module point_in_hexahedron_test (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic [2:0]                   in_corner_index,
  input  logic signed [pihex_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pihex_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [pihex_pkg::COORD_W-1:0] in_coord_z,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_inside_res,
  // Configuration
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data
);
  import pihex_pkg::*;

  // Sequencer states: one pass through RD0..D3 handles one face.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD0  = 4'd1;
  localparam logic [3:0] ST_RD1  = 4'd2;
  localparam logic [3:0] ST_RD2  = 4'd3;
  localparam logic [3:0] ST_M0   = 4'd4;
  localparam logic [3:0] ST_M1   = 4'd5;
  localparam logic [3:0] ST_N    = 4'd6;
  localparam logic [3:0] ST_D0   = 4'd7;
  localparam logic [3:0] ST_D1   = 4'd8;
  localparam logic [3:0] ST_D2   = 4'd9;
  localparam logic [3:0] ST_D3   = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  logic [3:0]        state_r,      state_nxt;
  logic [FACE_W-1:0] face_r,       face_nxt;
  logic              fail_r,       fail_nxt;
  corner_t           point_r,      point_nxt;
  logic              face_order_r, face_order_nxt;
  logic              out_valid_r,  out_valid_nxt;
  logic              out_inside_r, out_inside_nxt;

  logic              in_accept;
  logic              out_fire;
  logic              mem_wr_en;
  corner_t           mem_wr_data;
  logic [CIDX_W-1:0] rd_addr_a;
  logic [CIDX_W-1:0] rd_addr_b;
  corner_t           rd_data_a;
  corner_t           rd_data_b;
  face_t             fc;
  pihex_ctl_t        ctl;
  logic              dot_neg;

  // The input is taken only between queries.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign out_fire  = out_valid_r & ~out_stall;

  assign mem_wr_en   = in_accept & (in_mode == MODE_LOAD);
  assign mem_wr_data = '{z: in_coord_z, y: in_coord_y, x: in_coord_x};

  // Corners of the current face. Port A first reads c0, then c1; port B
  // reads c2 alongside c0.
  assign fc        = face_corners(face_order_r, face_r);
  assign rd_addr_a = (state_r == ST_RD0) ? fc.c0 : fc.c1;
  assign rd_addr_b = fc.c2;

  pihex_corner_mem u_corner_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (in_corner_index),
    .wr_data   (mem_wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  pihex_face_dp u_face_dp (
    .clk     (clk),
    .ctl     (ctl),
    .rd_a    (rd_data_a),
    .rd_b    (rd_data_b),
    .point   (point_r),
    .dot_neg (dot_neg)
  );

  always_comb begin
    state_nxt      = state_r;
    face_nxt       = face_r;
    fail_nxt       = fail_r;
    point_nxt      = point_r;
    face_order_nxt = cfg_wr_en ? cfg_wr_data : face_order_r;
    out_valid_nxt  = out_fire ? 1'b0 : out_valid_r;
    out_inside_nxt = out_inside_r;
    ctl            = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_mode == MODE_QUERY)) begin
          point_nxt = mem_wr_data;
          face_nxt  = '0;
          fail_nxt  = 1'b0;
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: begin
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        // c0 and c2 are out of the store: form c2 - c0 and p - c0.
        ctl.cap_a = 1'b1;
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        ctl.cap_b = 1'b1;
        state_nxt = ST_M0;
      end
      ST_M0: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_CROSS0;
        state_nxt   = ST_M1;
      end
      ST_M1: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_CROSS1;
        ctl.save_p1 = 1'b1;
        state_nxt   = ST_N;
      end
      ST_N: begin
        ctl.norm  = 1'b1;
        state_nxt = ST_D0;
      end
      ST_D0: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_DOT_LO;
        state_nxt   = ST_D1;
      end
      ST_D1: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MS_DOT_HI;
        ctl.lo_sum  = 1'b1;
        state_nxt   = ST_D2;
      end
      ST_D2: begin
        ctl.hi_sum = 1'b1;
        state_nxt  = ST_D3;
      end
      ST_D3: begin
        fail_nxt = fail_r | dot_neg;
        if (face_r == FACE_W'(NUM_FACES - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          face_nxt  = face_r + FACE_W'(1);
          state_nxt = ST_RD0;
        end
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = ~fail_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      face_order_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      face_order_r <= face_order_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    face_r       <= face_nxt;
    fail_r       <= fail_nxt;
    point_r      <= point_nxt;
    out_inside_r <= out_inside_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

endmodule

>>> rtl/pihex_corner_mem.sv
// ============================================================================
// pihex_corner_mem
// Corner store: eight entries of x, y and z, one write port and two read
// ports with registered read data.
// ============================================================================
module pihex_corner_mem (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [pihex_pkg::CIDX_W-1:0] wr_addr,
  input  pihex_pkg::corner_t      wr_data,
  input  logic [pihex_pkg::CIDX_W-1:0] rd_addr_a,
  input  logic [pihex_pkg::CIDX_W-1:0] rd_addr_b,
  output pihex_pkg::corner_t      rd_data_a,
  output pihex_pkg::corner_t      rd_data_b
);
  import pihex_pkg::*;

  corner_t mem [NUM_CORNERS];
  corner_t rd_a_r;
  corner_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

>>> rtl/pihex_face_dp.sv
// ============================================================================
// pihex_face_dp
// Face datapath: edge vectors, cross product and dot product of one face on
// three shared multiplier lanes, giving the sign of the dot product.
// ============================================================================
module pihex_face_dp (
  input  logic                 clk,
  input  pihex_pkg::pihex_ctl_t ctl,
  input  pihex_pkg::corner_t   rd_a,
  input  pihex_pkg::corner_t   rd_b,
  input  pihex_pkg::corner_t   point,
  output logic                 dot_neg
);
  import pihex_pkg::*;

  corner_t                  c0_r;
  logic signed [DIFF_W-1:0] a_r [NUM_LANES];
  logic signed [DIFF_W-1:0] b_r [NUM_LANES];
  logic signed [DIFF_W-1:0] d_r [NUM_LANES];
  logic signed [NORM_W-1:0] n_r [NUM_LANES];
  logic signed [PROD_W-1:0] prod_r [NUM_LANES];
  logic signed [PROD_W-1:0] p1_r [NUM_LANES];
  logic signed [SUM_W-1:0]  lo_sum_r;
  logic signed [SUM_W-1:0]  hi_sum_r;

  logic signed [MUL_W-1:0]  op_a [NUM_LANES];
  logic signed [MUL_W-1:0]  op_b [NUM_LANES];
  logic signed [PROD_W-1:0] prod_nxt [NUM_LANES];
  logic signed [NORM_W-1:0] n_wide [NUM_LANES];
  logic signed [SUM_W-1:0]  prod_sum;
  logic signed [DOT_W-1:0]  dot;

  function automatic logic signed [MUL_W-1:0] ext_d(input logic signed [DIFF_W-1:0] v);
    return signed'({v[DIFF_W-1], v});
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_p(input logic signed [PROD_W-1:0] v);
    return signed'({v[PROD_W-1], v});
  endfunction

  // Operand selection per lane. The cross product runs in two passes,
  // the dot product splits each normal component into a low unsigned half
  // and a high signed half.
  always_comb begin
    case (ctl.mul_sel)
      MS_CROSS0: begin
        op_a[0] = ext_d(a_r[1]);  op_b[0] = ext_d(b_r[2]);
        op_a[1] = ext_d(a_r[2]);  op_b[1] = ext_d(b_r[0]);
        op_a[2] = ext_d(a_r[0]);  op_b[2] = ext_d(b_r[1]);
      end
      MS_CROSS1: begin
        op_a[0] = ext_d(a_r[2]);  op_b[0] = ext_d(b_r[1]);
        op_a[1] = ext_d(a_r[0]);  op_b[1] = ext_d(b_r[2]);
        op_a[2] = ext_d(a_r[1]);  op_b[2] = ext_d(b_r[0]);
      end
      MS_DOT_LO: begin
        for (int k = 0; k < NUM_LANES; k++) begin
          op_a[k] = ext_d(d_r[k]);
          op_b[k] = signed'({1'b0, n_r[k][DIFF_W-1:0]});
        end
      end
      MS_DOT_HI: begin
        for (int k = 0; k < NUM_LANES; k++) begin
          op_a[k] = ext_d(d_r[k]);
          op_b[k] = signed'(n_r[k][NORM_W-1:DIFF_W]);
        end
      end
      default: begin
        for (int k = 0; k < NUM_LANES; k++) begin
          op_a[k] = '0;
          op_b[k] = '0;
        end
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      prod_nxt[k] = op_a[k] * op_b[k];
      n_wide[k]   = NORM_W'(p1_r[k] - prod_r[k]);
    end
  end

  assign prod_sum = ext_p(prod_r[0]) + ext_p(prod_r[1]) + ext_p(prod_r[2]);

  always_ff @(posedge clk) begin
    if (ctl.cap_a) begin
      c0_r   <= rd_a;
      a_r[0] <= coord_diff(rd_b.x, rd_a.x);
      a_r[1] <= coord_diff(rd_b.y, rd_a.y);
      a_r[2] <= coord_diff(rd_b.z, rd_a.z);
      d_r[0] <= coord_diff(point.x, rd_a.x);
      d_r[1] <= coord_diff(point.y, rd_a.y);
      d_r[2] <= coord_diff(point.z, rd_a.z);
    end
    if (ctl.cap_b) begin
      b_r[0] <= coord_diff(rd_a.x, c0_r.x);
      b_r[1] <= coord_diff(rd_a.y, c0_r.y);
      b_r[2] <= coord_diff(rd_a.z, c0_r.z);
    end
    for (int k = 0; k < NUM_LANES; k++) begin
      if (ctl.mul_en) begin
        prod_r[k] <= prod_nxt[k];
      end
      if (ctl.save_p1) begin
        p1_r[k] <= prod_r[k];
      end
      if (ctl.norm) begin
        n_r[k] <= n_wide[k];
      end
    end
    if (ctl.lo_sum) begin
      lo_sum_r <= prod_sum;
    end
    if (ctl.hi_sum) begin
      hi_sum_r <= prod_sum;
    end
  end

  // The high half carries the weight of the low half's bit count.
  assign dot = signed'({hi_sum_r[SUM_W-1], hi_sum_r, {DIFF_W{1'b0}}})
             + signed'({{(DOT_W-SUM_W){lo_sum_r[SUM_W-1]}}, lo_sum_r});

  assign dot_neg = dot[DOT_W-1];

endmodule

>>> rtl/pihex_checker.sv
// ============================================================================
// pihex_checker
// Port-level checks of the point-in-hexahedron test, bound to the top level.
// ============================================================================
module pihex_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_mode,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_inside_res
);
  import pihex_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inside_res))
    else $error("result beat changed while stalled");

  // A query keeps the block busy on the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == MODE_QUERY) |=> in_stall)
    else $error("query did not occupy the block");

  // A load leaves the input free on the next cycle.
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == MODE_LOAD) |=> !in_stall)
    else $error("load stalled the input");

  // A new result appears only at the end of a query.
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a query");

  // The end of a query always leaves a result pending.
  a_query_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid)
    else $error("query ended without a result");

endmodule

bind point_in_hexahedron_test pihex_checker u_pihex_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_mode         (in_mode),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_inside_res  (out_inside_res)
);

>>> verif/tb_point_in_hexahedron_test.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_point_in_hexahedron_test
// Self-checking bench for the point-in-hexahedron test block.
// ============================================================================
// Corner loads and point queries go in over the input channel, and a
// scoreboard predicts each inside/outside answer with exact wide integer
// arithmetic. Both channels idle and stall at random. The run covers both
// face orders, degenerate and extreme cells, and many random cells.
// ============================================================================
module tb_point_in_hexahedron_test;

  import pihex_pkg::*;

  localparam int  CLK_PERIOD   = 20;
  localparam int  RESET_CYCLES = 7;
  // Settle pause that leaves margin for a query to finish before config.
  localparam int  SETTLE_CYCLES = 80;
  // Worst quiet stretch: a query, a full output stall, a full input gap and
  // a settle pause before a config write. This is several times that.
  localparam int  QUIET_LIMIT  = 3000;
  localparam int  NUM_PHASES   = 6;
  localparam int  PHASE_BEATS  = 180;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam longint COORD_MAX = 64'sd2147483647;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the corner store and the face order,
  // predicts the answer of every accepted query and checks results in order.
  // --------------------------------------------------------------------------
  class hex_scoreboard;
    logic signed [COORD_W-1:0] corner_x [8];
    logic signed [COORD_W-1:0] corner_y [8];
    logic signed [COORD_W-1:0] corner_z [8];
    bit                        order_sel;
    bit                        inside_expected [$];
    bit [2:0]                  face_pick [2][6][3];
    int                        errors;
    int                        loads;
    int                        queries;
    int                        inside_count;

    function new();
      // Corners c0, c1, c2 of each face for both corner-order tables.
      face_pick = '{'{'{3'd0, 3'd2, 3'd1}, '{3'd4, 3'd5, 3'd6}, '{3'd0, 3'd4, 3'd2},
                      '{3'd1, 3'd3, 3'd5}, '{3'd0, 3'd1, 3'd4}, '{3'd2, 3'd6, 3'd3}},
                    '{'{3'd2, 3'd0, 3'd3}, '{3'd6, 3'd7, 3'd4}, '{3'd2, 3'd6, 3'd0},
                      '{3'd3, 3'd1, 3'd7}, '{3'd2, 3'd3, 3'd6}, '{3'd0, 3'd4, 3'd1}}};
      order_sel = 1'b0;
    endfunction

    // The normal of a face is (c2 - c0) x (c1 - c0). The point is out when
    // its offset from c0 has a negative dot product with any normal. The
    // magnitudes stay below 2^103, so 128 signed bits keep this exact.
    function bit point_is_in(logic signed [COORD_W-1:0] px,
                             logic signed [COORD_W-1:0] py,
                             logic signed [COORD_W-1:0] pz);
      logic signed [127:0] ax, ay, az, bx, by, bz, dx, dy, dz;
      logic signed [127:0] nx, ny, nz, dot;
      bit [2:0]            i0, i1, i2;
      for (int f = 0; f < 6; f++) begin
        i0 = face_pick[order_sel][f][0];
        i1 = face_pick[order_sel][f][1];
        i2 = face_pick[order_sel][f][2];
        ax = corner_x[i2];  ax = ax - corner_x[i0];
        ay = corner_y[i2];  ay = ay - corner_y[i0];
        az = corner_z[i2];  az = az - corner_z[i0];
        bx = corner_x[i1];  bx = bx - corner_x[i0];
        by = corner_y[i1];  by = by - corner_y[i0];
        bz = corner_z[i1];  bz = bz - corner_z[i0];
        dx = px;            dx = dx - corner_x[i0];
        dy = py;            dy = dy - corner_y[i0];
        dz = pz;            dz = dz - corner_z[i0];
        nx = ay * bz - az * by;
        ny = az * bx - ax * bz;
        nz = ax * by - ay * bx;
        dot = dx * nx + dy * ny + dz * nz;
        if (dot < 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_beat(logic mode, logic [2:0] idx,
                            logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y,
                            logic signed [COORD_W-1:0] z);
      bit hit;
      if (mode == MODE_LOAD) begin
        corner_x[idx] = x;
        corner_y[idx] = y;
        corner_z[idx] = z;
        loads++;
      end else begin
        hit = point_is_in(x, y, z);
        inside_expected = {inside_expected, hit};
        queries++;
        if (hit) inside_count++;
      end
    endfunction

    function void check_result(logic got);
      bit want;
      if (inside_expected.size() == 0) begin
        $display("%0t: inside_res expected none, actual %b", $time, got);
        errors++;
      end else begin
        want = inside_expected.pop_front();
        if (got !== want) begin
          $display("%0t: inside_res expected %b, actual %b", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return inside_expected.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals. Every block input starts at a known value.
  // --------------------------------------------------------------------------
  logic                      clk             = 1'b0;
  logic                      rst_n           = 1'b0;
  logic                      in_valid        = 1'b0;
  logic                      in_stall;
  logic                      in_mode         = MODE_LOAD;
  logic [2:0]                in_corner_index = 3'd0;
  logic signed [COORD_W-1:0] in_coord_x      = '0;
  logic signed [COORD_W-1:0] in_coord_y      = '0;
  logic signed [COORD_W-1:0] in_coord_z      = '0;
  logic                      out_valid;
  logic                      out_stall       = 1'b0;
  logic                      out_inside_res;
  logic                      cfg_wr_en       = 1'b0;
  logic                      cfg_wr_data     = 1'b0;

  hex_scoreboard sb;
  // When a calm flag is set, that side runs back to back with no idling.
  bit  in_calm  = 1'b0;
  bit  out_calm = 1'b0;
  int  out_hold = 0;
  int  quiet_cycles = 0;
  int  beats_sent = 0;

  point_in_hexahedron_test u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_corner_index (in_corner_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_inside_res  (out_inside_res),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result side. Every beat is checked at the edge that accepts it, and after
  // each accepted beat a fresh stall length is drawn. The stall counts down
  // whether or not a result is waiting, so stalls land on every phase of the
  // block's work.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_hold = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_inside_res);
        out_hold = out_calm ? 0 : $urandom_range(0, 17);
      end else if (out_hold > 0) begin
        out_hold = out_hold - 1;
      end
      out_stall <= (out_hold != 0);
    end
  end

  // Watchdog: the run is hung if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout after %0d quiet cycles at %0t", quiet_cycles, $time);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side. An optional gap of idle cycles comes first, then the beat is
  // held until the block takes it. Signals read right after the edge still
  // hold their values from before it, so the stall test is race free. The
  // valid is only lowered at the start of a gap, never at the accepting edge,
  // so a back-to-back beat keeps it high without a second assignment.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic mode, input logic [2:0] idx,
                           input longint x, input longint y, input longint z);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_corner_index <= idx;
    in_coord_x      <= x[COORD_W-1:0];
    in_coord_y      <= y[COORD_W-1:0];
    in_coord_z      <= z[COORD_W-1:0];
    do @(posedge clk); while (in_stall);
    sb.note_beat(mode, idx, x[COORD_W-1:0], y[COORD_W-1:0], z[COORD_W-1:0]);
    beats_sent++;
  endtask

  // Drops valid, waits for every answer, then lets the block settle since a
  // trailing load gives nothing to wait for. Only then is face_order written.
  task automatic drain_inputs();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_face_order(input bit order);
    drain_inputs();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= order;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.order_sel = order;
  endtask

  // Uniform offset in [-r, r].
  function automatic longint spread(longint r);
    return longint'($urandom_range(0, 32'(2 * r))) - r;
  endfunction

  // --------------------------------------------------------------------------
  // One random cell. Most cells are well-formed boxes, jittered into general
  // hexahedra, loaded in a random corner order and then queried with points
  // inside, outside, on corners and on faces. The corner layout matches the
  // current face order most of the time, so both answers show up often; the
  // rest use the other layout, which turns the faces inside out. A few cells
  // are pure noise with full-range coordinates, and a few only partly reload
  // the previous cell.
  // --------------------------------------------------------------------------
  task automatic run_cell();
    longint cxl [8];
    longint cyl [8];
    longint czl [8];
    int     load_order [8];
    longint ctr_x, ctr_y, ctr_z, h, jit, px, py, pz, zs;
    int     kind, nq, nl, k, t, sel, e;
    bit     layout;

    in_calm  = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
    kind = $urandom_range(0, 9);

    if (kind == 0) begin
      // Noise: random corners anywhere, random points anywhere.
      nl = $urandom_range(1, 3);
      for (int i = 0; i < nl; i++)
        send_beat(MODE_LOAD, 3'($urandom_range(0, 7)), longint'($signed($urandom())),
                  longint'($signed($urandom())), longint'($signed($urandom())));
      nq = $urandom_range(1, 2);
      for (int i = 0; i < nq; i++)
        send_beat(MODE_QUERY, 3'($urandom_range(0, 7)), longint'($signed($urandom())),
                  longint'($signed($urandom())), longint'($signed($urandom())));
      return;
    end

    // Box size spans tiny to large; center and jitter keep every corner and
    // every query point within the signed 32-bit range.
    e     = $urandom_range(1, 29);
    h     = longint'($urandom_range(1, 32'(1 << e)));
    jit   = ($urandom_range(0, 2) == 0) ? 0 : h / 4;
    ctr_x = longint'($signed($urandom()) >>> 1);
    ctr_y = longint'($signed($urandom()) >>> 1);
    ctr_z = longint'($signed($urandom()) >>> 1);
    // The second table expects z to fall as corner bit 2 is set.
    layout = sb.order_sel ^ ($urandom_range(0, 3) == 0);

    for (int i = 0; i < 8; i++) begin
      zs = (i[2] ^ layout) ? h : -h;
      cxl[i] = ctr_x + (i[0] ? h : -h) + spread(jit);
      cyl[i] = ctr_y + (i[1] ? h : -h) + spread(jit);
      czl[i] = ctr_z + zs + spread(jit);
      load_order[i] = i;
    end
    for (int i = 7; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = load_order[i];
      load_order[i] = load_order[k];
      load_order[k] = t;
    end

    // A broken cell stops part way, leaving older corners in the store.
    nl = (kind == 1) ? $urandom_range(1, 7) : 8;
    for (int i = 0; i < nl; i++) begin
      k = load_order[i];
      send_beat(MODE_LOAD, 3'(k), cxl[k], cyl[k], czl[k]);
    end

    nq = $urandom_range(2, 6);
    for (int i = 0; i < nq; i++) begin
      sel = $urandom_range(0, 3);
      k   = $urandom_range(0, 7);
      case (sel)
        0: begin
          px = cxl[k];  py = cyl[k];  pz = czl[k];
        end
        1: begin
          px = ctr_x + spread(h / 2);
          py = ctr_y + spread(h / 2);
          pz = ctr_z + spread(h / 2);
        end
        2: begin
          px = ctr_x + spread(h + h / 2);
          py = ctr_y + spread(h + h / 2);
          pz = ctr_z + spread(h + h / 2);
        end
        default: begin
          // Center of one face of the unjittered box.
          px = ctr_x;  py = ctr_y;  pz = ctr_z;
          case (k % 3)
            0:       px = px + (k[2] ? h : -h);
            1:       py = py + (k[2] ? h : -h);
            default: pz = pz + (k[2] ? h : -h);
          endcase
        end
      endcase
      send_beat(MODE_QUERY, 3'($urandom_range(0, 7)), px, py, pz);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    sb = new();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_face_order(1'b0);

    // Directed, all back to back. First a degenerate cell: every corner at the
    // same spot, so every normal is zero and no face can reject the point.
    in_calm  = 1'b1;
    out_calm = 1'b1;
    for (int i = 0; i < 8; i++)
      send_beat(MODE_LOAD, 3'(i), COORD_MIN, COORD_MAX, 0);
    send_beat(MODE_QUERY, 3'd7, COORD_MAX, COORD_MIN, COORD_MIN);

    // A box spanning the whole coordinate range, then its center, one of its
    // corners, the middle of one face and a point just off the center.
    for (int i = 0; i < 8; i++)
      send_beat(MODE_LOAD, 3'(i), i[0] ? COORD_MAX : COORD_MIN,
                i[1] ? COORD_MAX : COORD_MIN, i[2] ? COORD_MAX : COORD_MIN);
    send_beat(MODE_QUERY, 3'd0, 0, 0, 0);
    send_beat(MODE_QUERY, 3'd5, COORD_MAX, COORD_MAX, COORD_MAX);
    send_beat(MODE_QUERY, 3'd2, COORD_MIN, 0, 0);
    send_beat(MODE_QUERY, 3'd3, -1, -1, -1);

    // Random phases alternate the face order, starting with the second table.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_face_order((ph % 2) == 0);
      beats_sent = 0;
      while (beats_sent < PHASE_BEATS) run_cell();
    end

    drain_inputs();

    $display("Sent %0d corner loads and %0d point queries; %0d points were inside.",
             sb.loads, sb.queries, sb.inside_count);
    $display("Both face orders, degenerate and full-range cells were exercised.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
